// ===== design/bpsd_pkg.sv =====
package bpsd_pkg;

    localparam int MAX_BANDS   = 256;
    localparam int MAX_COLUMNS = 1024;
    localparam int ROWS_LIMIT  = 4096;

    localparam int BAND_W = $clog2(MAX_BANDS);
    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(ROWS_LIMIT);

    localparam int COLS_CFG_W  = 11;
    localparam int BANDS_CFG_W = 9;
    localparam int ROWS_CFG_W  = 13;

    localparam int SAMPLE_W = 16;
    localparam int REF_W    = 16;
    localparam int SQ_W     = 2 * REF_W;
    localparam int ACC_W    = 40;
    localparam int DIST_W   = ACC_W / 2;
    localparam int REM_W    = DIST_W + 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_BANDS   = 2'd1;
    localparam logic [1:0] REG_ROWS    = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [BAND_W-1:0]          ref_band;
        logic [REF_W-1:0]           ref_value;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [COL_W-1:0]  pixel_column;
        logic [ROW_W-1:0]  pixel_row;
        logic              line_done;
        logic              image_done;
    } out_item_t;

endpackage

// ===== design/bil_pixel_spectral_distance_unit.sv =====
// Spectral distance of each pixel of a band-interleaved-by-line image to one
// reference spectrum. A load transaction writes a reference value; loads and
// register writes restart the column, band and row counters. A sample
// transaction steps through accept, difference against the registered
// reference, square, and accumulator read-modify-write. On the last band of a
// pixel a bit-pair square root unit runs and then hands its result into the
// output register, which lets the result wait while the next transaction is
// accepted. Samples of zero or below count as missing. Registers read back as
// written; zero acts as one and values above the maximum saturate.
module bil_pixel_spectral_distance_unit
    import bpsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SQRT_STEPS = DIST_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQUARE,
        S_ACC,
        S_SQRT,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [REF_W-1:0] ref_mem [MAX_BANDS];
    logic [ACC_W-1:0] acc_mem [MAX_COLUMNS];

    logic [COLS_CFG_W-1:0]  columns_reg;
    logic [BANDS_CFG_W-1:0] bands_reg;
    logic [ROWS_CFG_W-1:0]  rows_reg;

    logic [COL_W-1:0]  column_count_reg;
    logic [BAND_W-1:0] band_count_reg;
    logic [ROW_W-1:0]  row_count_reg;

    logic [REF_W-1:0]           ref_rd_reg;
    logic [ACC_W-1:0]           acc_rd_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [REF_W-1:0]           abs_diff_reg;
    logic [SQ_W-1:0]            square_reg;

    logic [ACC_W-1:0]  radicand_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;

    logic [COL_W-1:0] pix_col_reg;
    logic [ROW_W-1:0] pix_row_reg;
    logic             line_done_reg;
    logic             image_done_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic [COLS_CFG_W-1:0]  cols_eff;
    logic [BANDS_CFG_W-1:0] bands_eff;
    logic [ROWS_CFG_W-1:0]  rows_eff;
    logic                   last_col;
    logic                   last_band;
    logic                   last_row;
    logic                   s_accept;
    logic                   cfg_write;
    logic                   out_free;
    logic signed [SAMPLE_W+1:0] diff;
    logic [SAMPLE_W+1:0]    diff_mag;
    logic                   sample_present;
    logic [ACC_W-1:0]       acc_sum;
    logic [REM_W+1:0]       rem_shift;
    logic [REM_W+1:0]       trial;

    always_comb begin
        cols_eff = columns_reg;
        if (columns_reg == '0) begin
            cols_eff = COLS_CFG_W'(1);
        end else if (columns_reg > COLS_CFG_W'(MAX_COLUMNS)) begin
            cols_eff = COLS_CFG_W'(MAX_COLUMNS);
        end
        bands_eff = bands_reg;
        if (bands_reg == '0) begin
            bands_eff = BANDS_CFG_W'(1);
        end else if (bands_reg > BANDS_CFG_W'(MAX_BANDS)) begin
            bands_eff = BANDS_CFG_W'(MAX_BANDS);
        end
        rows_eff = rows_reg;
        if (rows_reg == '0) begin
            rows_eff = ROWS_CFG_W'(1);
        end else if (rows_reg > ROWS_CFG_W'(ROWS_LIMIT)) begin
            rows_eff = ROWS_CFG_W'(ROWS_LIMIT);
        end
    end

    assign last_col  = (column_count_reg == COL_W'(cols_eff - COLS_CFG_W'(1)));
    assign last_band = (band_count_reg == BAND_W'(bands_eff - BANDS_CFG_W'(1)));
    assign last_row  = (row_count_reg == ROW_W'(rows_eff - ROWS_CFG_W'(1)));

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign pready    = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_COLUMNS: prdata = APB_DATA_W'(columns_reg);
            REG_BANDS:   prdata = APB_DATA_W'(bands_reg);
            REG_ROWS:    prdata = APB_DATA_W'(rows_reg);
            default:     prdata = '0;
        endcase
    end

    assign diff = $signed({{2{sample_reg[SAMPLE_W-1]}}, sample_reg})
                - $signed({2'b00, ref_rd_reg});
    assign diff_mag = diff[SAMPLE_W+1] ? (SAMPLE_W+2)'(-diff) : (SAMPLE_W+2)'(diff);
    assign sample_present = !sample_reg[SAMPLE_W-1] && (sample_reg != '0);

    assign acc_sum = (band_count_reg == '0) ? ACC_W'(square_reg)
                                            : acc_rd_reg + ACC_W'(square_reg);

    // One restoring step of the square root: two radicand bits per cycle.
    assign rem_shift = {rem_reg, radicand_reg[ACC_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    // Reference store: written by load transactions, read at the band counter.
    always_ff @(posedge aclk) begin
        if (s_accept && s_data.kind == KIND_LOAD) begin
            ref_mem[s_data.ref_band] <= s_data.ref_value;
        end
        ref_rd_reg <= ref_mem[band_count_reg];
    end

    // Accumulators: read and written at the column counter.
    always_ff @(posedge aclk) begin
        if (state_reg == S_ACC) begin
            acc_mem[column_count_reg] <= acc_sum;
        end
        acc_rd_reg <= acc_mem[column_count_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            columns_reg      <= COLS_CFG_W'(100);
            bands_reg        <= BANDS_CFG_W'(198);
            rows_reg         <= ROWS_CFG_W'(100);
            column_count_reg <= '0;
            band_count_reg   <= '0;
            row_count_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_write) begin
                unique case (paddr[3:2])
                    REG_COLUMNS: begin
                        columns_reg      <= pwdata[COLS_CFG_W-1:0];
                        column_count_reg <= '0;
                        band_count_reg   <= '0;
                        row_count_reg    <= '0;
                    end
                    REG_BANDS: begin
                        bands_reg        <= pwdata[BANDS_CFG_W-1:0];
                        column_count_reg <= '0;
                        band_count_reg   <= '0;
                        row_count_reg    <= '0;
                    end
                    REG_ROWS: begin
                        rows_reg         <= pwdata[ROWS_CFG_W-1:0];
                        column_count_reg <= '0;
                        band_count_reg   <= '0;
                        row_count_reg    <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_data.kind == KIND_LOAD) begin
                            column_count_reg <= '0;
                            band_count_reg   <= '0;
                            row_count_reg    <= '0;
                        end else begin
                            sample_reg <= s_data.sample;
                            state_reg  <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    abs_diff_reg <= sample_present ? diff_mag[REF_W-1:0] : '0;
                    state_reg    <= S_SQUARE;
                end
                S_SQUARE: begin
                    square_reg <= abs_diff_reg * abs_diff_reg;
                    state_reg  <= S_ACC;
                end
                S_ACC: begin
                    pix_col_reg    <= column_count_reg;
                    pix_row_reg    <= row_count_reg;
                    line_done_reg  <= last_col;
                    image_done_reg <= last_col && last_row;
                    radicand_reg   <= acc_sum;
                    rem_reg        <= '0;
                    root_reg       <= '0;
                    step_reg       <= '0;
                    state_reg      <= last_band ? S_SQRT : S_IDLE;
                    if (last_col) begin
                        column_count_reg <= '0;
                        if (last_band) begin
                            band_count_reg <= '0;
                            row_count_reg  <= last_row ? '0 : row_count_reg + ROW_W'(1);
                        end else begin
                            band_count_reg <= band_count_reg + BAND_W'(1);
                        end
                    end else begin
                        column_count_reg <= column_count_reg + COL_W'(1);
                    end
                end
                S_SQRT: begin
                    radicand_reg <= {radicand_reg[ACC_W-3:0], 2'b00};
                    if (rem_shift >= trial) begin
                        rem_reg  <= REM_W'(rem_shift - trial);
                        root_reg <= {root_reg[DIST_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_shift[REM_W-1:0];
                        root_reg <= {root_reg[DIST_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_data_reg.distance     <= root_reg;
                        m_data_reg.pixel_column <= pix_col_reg;
                        m_data_reg.pixel_row    <= pix_row_reg;
                        m_data_reg.line_done    <= line_done_reg;
                        m_data_reg.image_done   <= image_done_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_sample_reads_memory: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_data.kind == KIND_SAMPLE |=> state_reg == S_DIFF)
        else $error("sample transaction did not start the accumulator read");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (COLS_CFG_W'(column_count_reg) < cols_eff) && (BANDS_CFG_W'(band_count_reg) < bands_eff)
        && (ROWS_CFG_W'(row_count_reg) < rows_eff))
        else $error("position counter beyond the configured image size");

    a_result_from_root: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised without a finished square root");

    a_root_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SQRT |-> step_reg < STEP_W'(SQRT_STEPS))
        else $error("square root ran past its last step");

endmodule
